FILE: rtl/core/tsdb_pkg.sv
// Shared types and constants for the triangle span depth buffer.
// No dependencies; imported by every module of the block but tsdb_fifo.
`default_nettype none

package tsdb_pkg;

    localparam logic [1:0] ACT_PLOT  = 2'd0;
    localparam logic [1:0] ACT_TRI   = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    localparam int CX_W  = 16;   // corner x, 1/64 pixel
    localparam int CY_W  = 15;   // corner y, 1/64 pixel
    localparam int PX_W  = 11;   // pixel column, rounded or floored from CX_W
    localparam int PY_W  = 10;   // pixel row, rounded or floored from CY_W
    localparam int DEP_W = 16;
    localparam int CNT_W = 16;
    localparam int DIM_W = 13;   // image dimension up to 8191
    localparam int NUM_W = 31;   // edge numerator, never negative
    localparam int DEN_W = 22;   // 64 * x span

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [1:0]       action;
        logic             ok;      // pixel inside, or triangle not skipped
        logic [PX_W-1:0]  px;
        logic [PY_W-1:0]  py;
        logic [CX_W-1:0]  x0, x1, x2;   // sorted by x, stable
        logic [CY_W-1:0]  y0, y1, y2;
        logic [DEP_W-1:0] depth;
    } t_cmd;

    typedef struct packed {
        logic [DEP_W-1:0] read_depth;
        logic [CNT_W-1:0] pixels_lowered;
        logic             accepted;
    } t_res;

endpackage

`default_nettype wire

FILE: rtl/core/triangle_span_depth_buffer.sv
// Top level of the triangle span depth buffer: front end, command queue,
// back end with depth memory, result queue. Depends on tsdb_pkg and submodules.
//
// Usage
//   Input channel is a queue write: a word is taken on a rising edge with
//   push high and full low. Actions: plot a vertex, fill a triangle, read a
//   pixel, clear the whole buffer. Every word yields exactly one result word.
//   Result channel is a queue read: while empty is low the oldest result sits
//   on o_read_depth / o_pixels_lowered / o_accepted; pop takes it. depth_limit
//   is written (i_cfg_we / i_cfg_wdata) by the user only while idle; unchecked.
// Timing
//   Words are handled one at a time by the back-end sequencer; a two-word
//   queue on each side lets the front keep taking words meanwhile.
//   Plot: S_PADDR, S_PEXEC, S_RES; read adds S_RDCAP; skipped triangle: S_RES.
//   Clear: one memory cell per cycle, all IMAGE_WIDTH*IMAGE_HEIGHT cells.
//   Triangle: in each column both edge divisions run in turn on the shared
//   restoring divider, then each covered row takes a read (S_RD) and a
//   compare-and-write (S_CMP) as a read-modify-write on the depth memory.
// Reset
//   After reset a clearing pass zeroes the whole memory; full stays high until
//   it ends. A stalled result side fills the result queue, then the sequencer
//   waits and the input queue backs up.
`default_nettype none

module triangle_span_depth_buffer
    import tsdb_pkg::*;
#(
    parameter int IMAGE_WIDTH  = 640,
    parameter int IMAGE_HEIGHT = 480
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [1:0]       i_action,
    input  wire logic [CX_W-1:0]  i_corner_a_x,
    input  wire logic [CY_W-1:0]  i_corner_a_y,
    input  wire logic [CX_W-1:0]  i_corner_b_x,
    input  wire logic [CY_W-1:0]  i_corner_b_y,
    input  wire logic [CX_W-1:0]  i_corner_c_x,
    input  wire logic [CY_W-1:0]  i_corner_c_y,
    input  wire logic [DEP_W-1:0] i_item_depth,
    output logic                  empty,
    input  wire logic             pop,
    output logic [DEP_W-1:0]      o_read_depth,
    output logic [CNT_W-1:0]      o_pixels_lowered,
    output logic                  o_accepted,
    input  wire logic             i_cfg_we,
    input  wire logic [DEP_W-1:0] i_cfg_wdata
);

    localparam logic [DEP_W-1:0] LIMIT_RESET = 16'hC000;   // 1.5 in Q1.15

    logic [DEP_W-1:0] r_depth_limit;

    logic init_done;
    logic cq_push, cq_full, cq_pop, cq_empty;
    t_cmd cq_in, cq_out;
    logic rq_push, rq_full;
    t_res rq_in, rq_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_depth_limit <= i_cfg_wdata;
        end
    end

    tsdb_front #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_action    (i_action),
        .i_ax        (i_corner_a_x),
        .i_ay        (i_corner_a_y),
        .i_bx        (i_corner_b_x),
        .i_by        (i_corner_b_y),
        .i_cx        (i_corner_c_x),
        .i_cy        (i_corner_c_y),
        .i_depth     (i_item_depth),
        .i_init_done (init_done),
        .i_q_full    (cq_full),
        .o_full      (full),
        .o_q_push    (cq_push),
        .o_q_cmd     (cq_in)
    );

    // command queue between the front and the sequencer
    tsdb_fifo #(
        .WIDTH ($bits(t_cmd))
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cq_push),
        .i_data  (cq_in),
        .o_full  (cq_full),
        .i_pop   (cq_pop),
        .o_data  (cq_out),
        .o_empty (cq_empty)
    );

    tsdb_back #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_depth_limit (r_depth_limit),
        .i_cmd         (cq_out),
        .i_cmd_empty   (cq_empty),
        .o_cmd_pop     (cq_pop),
        .o_res         (rq_in),
        .o_res_push    (rq_push),
        .i_res_full    (rq_full),
        .o_init_done   (init_done)
    );

    // result queue decouples the sequencer from a stalling reader
    tsdb_fifo #(
        .WIDTH ($bits(t_res))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rq_push),
        .i_data  (rq_in),
        .o_full  (rq_full),
        .i_pop   (pop),
        .o_data  (rq_out),
        .o_empty (empty)
    );

    assign o_read_depth     = rq_out.read_depth;
    assign o_pixels_lowered = rq_out.pixels_lowered;
    assign o_accepted       = rq_out.accepted;

endmodule

`default_nettype wire

FILE: rtl/core/tsdb_fifo.sv
// Two-entry queue for words between the parts of the depth buffer.
// No package dependencies.
`default_nettype none

module tsdb_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tsdb_front.sv
// Front end: accepts input words, rounds positions, checks bounds,
// sorts triangle corners. Depends on tsdb_pkg.
`default_nettype none

module tsdb_front
    import tsdb_pkg::*;
#(
    parameter int IMAGE_WIDTH  = 640,
    parameter int IMAGE_HEIGHT = 480
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [1:0]       i_action,
    input  wire logic [CX_W-1:0]  i_ax,
    input  wire logic [CY_W-1:0]  i_ay,
    input  wire logic [CX_W-1:0]  i_bx,
    input  wire logic [CY_W-1:0]  i_by,
    input  wire logic [CX_W-1:0]  i_cx,
    input  wire logic [CY_W-1:0]  i_cy,
    input  wire logic [DEP_W-1:0] i_depth,
    input  wire logic             i_init_done,
    input  wire logic             i_q_full,
    output logic                  o_full,
    output logic                  o_q_push,
    output t_cmd                  o_q_cmd
);

    localparam logic [DIM_W-1:0] W_LIM = DIM_W'(IMAGE_WIDTH);
    localparam logic [DIM_W-1:0] H_LIM = DIM_W'(IMAGE_HEIGHT);

    logic            r_valid;
    t_cmd            r_cmd;
    t_cmd            n_cmd;
    logic            accept;
    logic [CX_W:0]   x_sum;
    logic [CY_W:0]   y_sum;
    logic [PX_W-1:0] px;
    logic [PY_W-1:0] py;
    logic            in_bounds, skip;
    logic            ab, ac, bc;    // later corner has strictly smaller x
    logic [1:0]      rank_a, rank_b, rank_c;

    assign o_full   = !i_init_done || (r_valid && i_q_full);
    assign accept   = i_push && !o_full;
    assign o_q_push = r_valid;
    assign o_q_cmd  = r_cmd;

    assign x_sum = {1'b0, i_ax} + (CX_W+1)'(32);
    assign y_sum = {1'b0, i_ay} + (CY_W+1)'(32);
    assign px    = x_sum[CX_W:6];
    assign py    = y_sum[CY_W:6];

    assign in_bounds = (px != '0) && ({2'b0, px} <= W_LIM)
                    && (py != '0) && ({3'b0, py} <= H_LIM);
    assign skip   = ((i_ax == '0) && (i_ay == '0)) || ((i_bx == '0) && (i_by == '0))
                 || ((i_cx == '0) && (i_cy == '0));

    // stable rank: on equal x the earlier corner goes first
    assign ab = i_ax > i_bx;
    assign ac = i_ax > i_cx;
    assign bc = i_bx > i_cx;
    assign rank_a = 2'(ab) + 2'(ac);
    assign rank_b = 2'(!ab) + 2'(bc);
    assign rank_c = 2'(!ac) + 2'(!bc);

    always_comb begin
        n_cmd        = '0;
        n_cmd.action = i_action;
        n_cmd.px     = px;
        n_cmd.py     = py;
        n_cmd.depth  = i_depth;
        n_cmd.ok     = (i_action == ACT_TRI) ? !skip : in_bounds;
        case (rank_a)
            2'd0:    begin n_cmd.x0 = i_ax; n_cmd.y0 = i_ay; end
            2'd1:    begin n_cmd.x1 = i_ax; n_cmd.y1 = i_ay; end
            default: begin n_cmd.x2 = i_ax; n_cmd.y2 = i_ay; end
        endcase
        case (rank_b)
            2'd0:    begin n_cmd.x0 = i_bx; n_cmd.y0 = i_by; end
            2'd1:    begin n_cmd.x1 = i_bx; n_cmd.y1 = i_by; end
            default: begin n_cmd.x2 = i_bx; n_cmd.y2 = i_by; end
        endcase
        case (rank_c)
            2'd0:    begin n_cmd.x0 = i_cx; n_cmd.y0 = i_cy; end
            2'd1:    begin n_cmd.x1 = i_cx; n_cmd.y1 = i_cy; end
            default: begin n_cmd.x2 = i_cx; n_cmd.y2 = i_cy; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (!i_q_full) begin
            r_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tsdb_div.sv
// Restoring divider, one quotient bit per cycle, for edge row floors.
// Depends on tsdb_pkg.
`default_nettype none

module tsdb_div
    import tsdb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_busy,
    output logic [NUM_W-1:0]      o_quot
);

    localparam int CW = $clog2(NUM_W);

    logic [NUM_W-1:0] r_num, r_quot;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   r_rem;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic [DEN_W:0]   rem_sh;
    logic             fits;

    assign rem_sh = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
    assign fits   = rem_sh >= {1'b0, r_den};
    assign o_busy = r_busy;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[NUM_W-2:0], 1'b0};
            r_rem  <= fits ? rem_sh - {1'b0, r_den} : rem_sh;
            r_quot <= {r_quot[NUM_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(NUM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tsdb_back.sv
// Back end: sequencer that owns the depth memory, plots, reads, clears
// and walks triangle spans. Depends on tsdb_pkg and tsdb_div.
`default_nettype none

module tsdb_back
    import tsdb_pkg::*;
#(
    parameter int IMAGE_WIDTH  = 640,
    parameter int IMAGE_HEIGHT = 480
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [DEP_W-1:0] i_depth_limit,
    input  wire t_cmd             i_cmd,
    input  wire logic             i_cmd_empty,
    output logic                  o_cmd_pop,
    output t_res                  o_res,
    output logic                  o_res_push,
    input  wire logic             i_res_full,
    output logic                  o_init_done
);

    localparam int CELLS = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam logic [DIM_W-1:0] W_LIM = DIM_W'(IMAGE_WIDTH);
    localparam logic [DIM_W-1:0] H_LIM = DIM_W'(IMAGE_HEIGHT);
    localparam logic [AW-1:0]    LAST  = AW'(CELLS - 1);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_PADDR = 4'd2;
    localparam logic [3:0] S_PEXEC = 4'd3;
    localparam logic [3:0] S_RDCAP = 4'd4;
    localparam logic [3:0] S_SPAN  = 4'd5;
    localparam logic [3:0] S_COL   = 4'd6;
    localparam logic [3:0] S_MUL   = 4'd7;
    localparam logic [3:0] S_SUM   = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_RD    = 4'd10;
    localparam logic [3:0] S_CMP   = 4'd11;
    localparam logic [3:0] S_RES   = 4'd12;

    logic [DEP_W-1:0] r_mem [CELLS];
    logic [DEP_W-1:0] r_mem_q;

    logic [3:0]        r_state;
    logic              r_init_done, r_clr_item, r_span, r_edge;
    t_cmd              r_cmd;
    t_res              r_res;
    logic [AW-1:0]     r_clr_addr, r_base;
    logic [PX_W-1:0]   r_k, r_k1;
    logic [PY_W-1:0]   r_f1, r_row, r_row1;
    logic [NUM_W-1:0]  r_p1;
    logic signed [33:0] r_p2;

    logic [AW-1:0]     addr;
    logic [PY_W-1:0]   row_sel;
    logic [PX_W-1:0]   col_m1;
    logic [PX_W+DIM_W-1:0] base_prod;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DEP_W-1:0]  mem_wdata;
    logic              lower;

    logic [CX_W-1:0]   sx, ex, epx, eqx;
    logic [CY_W-1:0]   epy, eqy;
    logic [CX_W-1:0]   den;
    logic signed [CX_W-1:0] dy;
    logic signed [17:0] u;
    logic signed [34:0] t_sum;
    logic [PX_W-1:0]   k0, k1;
    logic              div_start, div_busy;
    logic [NUM_W-1:0]  div_quot;
    logic [PY_W-1:0]   fq, f_lo, f_hi, hi_clip;

    // span ends: first span x0..x1, second x1..x2
    assign sx = r_span ? r_cmd.x1 : r_cmd.x0;
    assign ex = r_span ? r_cmd.x2 : r_cmd.x1;
    assign k0 = {1'b0, sx[CX_W-1:6]} + 1'b1;
    assign k1 = (W_LIM < {3'b0, ex[CX_W-1:6]}) ? W_LIM[PX_W-1:0] : {1'b0, ex[CX_W-1:6]};

    // edge 0 is the short edge of the span, edge 1 the long edge x0..x2
    always_comb begin
        if (r_edge) begin
            epx = r_cmd.x0; epy = r_cmd.y0; eqx = r_cmd.x2; eqy = r_cmd.y2;
        end else if (r_span) begin
            epx = r_cmd.x1; epy = r_cmd.y1; eqx = r_cmd.x2; eqy = r_cmd.y2;
        end else begin
            epx = r_cmd.x0; epy = r_cmd.y0; eqx = r_cmd.x1; eqy = r_cmd.y1;
        end
    end

    assign den   = eqx - epx;
    assign dy    = signed'({1'b0, eqy}) - signed'({1'b0, epy});
    assign u     = signed'({1'b0, r_k, 6'b0}) - signed'({2'b0, epx});
    // numerator is py*den + dy*(64k - px); non-negative inside a span
    assign t_sum = signed'({4'b0, r_p1}) + 35'(r_p2);
    assign div_start = (r_state == S_SUM);

    tsdb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (t_sum[NUM_W-1:0]),
        .i_den   ({den, 6'b0}),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    assign fq      = div_quot[PY_W-1:0];
    assign f_lo    = (r_f1 < fq) ? r_f1 : fq;
    assign f_hi    = (r_f1 < fq) ? fq : r_f1;
    assign hi_clip = (H_LIM < {3'b0, f_hi}) ? H_LIM[PY_W-1:0] : f_hi;

    assign col_m1    = ((r_state == S_PADDR) ? r_cmd.px : r_k) - 1'b1;
    assign base_prod = col_m1 * H_LIM;
    assign row_sel   = (r_state == S_PEXEC) ? r_cmd.py : r_row;
    assign addr      = r_base + AW'(row_sel) - 1'b1;

    assign lower = (r_mem_q != '0) && (r_mem_q > r_cmd.depth);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = addr;
        mem_wdata = r_cmd.depth;
        case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
            end
            S_PEXEC: mem_we = (r_cmd.action == ACT_PLOT) && (r_cmd.depth < i_depth_limit);
            S_CMP:   mem_we = lower;
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= r_mem[addr];
    end

    assign o_cmd_pop   = (r_state == S_IDLE);
    assign o_res_push  = (r_state == S_RES);
    assign o_res       = r_res;
    assign o_init_done = r_init_done;

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cmd  <= i_cmd;
                r_res  <= '0;
                r_span <= 1'b0;
            end
            S_PADDR: r_base <= AW'(base_prod);
            S_PEXEC: r_res.accepted <= 1'b1;
            S_RDCAP: r_res.read_depth <= r_mem_q;
            S_SPAN: begin
                r_k  <= k0;
                r_k1 <= k1;
            end
            S_COL: begin
                r_edge <= 1'b0;
                if (r_k > r_k1) begin
                    r_span <= 1'b1;
                    r_res.accepted <= r_span;
                end
            end
            S_MUL: begin
                r_p1   <= NUM_W'(epy * den);
                r_p2   <= dy * u;
                r_base <= AW'(base_prod);
            end
            S_DIV: begin
                if (!div_busy) begin
                    r_f1   <= fq;
                    r_edge <= 1'b1;
                    r_row  <= f_lo + 1'b1;
                    r_row1 <= hi_clip;
                end
            end
            S_RD: begin
                if (r_row > r_row1) begin
                    r_k <= r_k + 1'b1;
                end
            end
            S_CMP: begin
                r_row <= r_row + 1'b1;
                if (lower && (r_res.pixels_lowered != CNT_MAX)) begin
                    r_res.pixels_lowered <= r_res.pixels_lowered + 1'b1;
                end
            end
            S_CLR: begin
                // result was zeroed when the clear word was taken
                if (r_clr_addr == LAST) begin
                    r_res.accepted <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_clr_item  <= 1'b0;
            r_init_done <= 1'b0;
        end else begin
            case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == LAST) begin
                        r_init_done <= 1'b1;
                        r_state     <= r_clr_item ? S_RES : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (!i_cmd_empty) begin
                        case (i_cmd.action)
                            ACT_TRI:   r_state <= i_cmd.ok ? S_SPAN : S_RES;
                            ACT_CLEAR: begin
                                r_clr_addr <= '0;
                                r_clr_item <= 1'b1;
                                r_state    <= S_CLR;
                            end
                            default:   r_state <= i_cmd.ok ? S_PADDR : S_RES;
                        endcase
                    end
                end
                S_PADDR: r_state <= S_PEXEC;
                S_PEXEC: r_state <= (r_cmd.action == ACT_READ) ? S_RDCAP : S_RES;
                S_RDCAP: r_state <= S_RES;
                S_SPAN:  r_state <= S_COL;
                S_COL: begin
                    if (r_k > r_k1) begin
                        r_state <= r_span ? S_RES : S_SPAN;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL:   r_state <= S_SUM;
                S_SUM:   r_state <= S_DIV;
                S_DIV: begin
                    if (!div_busy) begin
                        r_state <= r_edge ? S_RD : S_MUL;
                    end
                end
                S_RD:    r_state <= (r_row > r_row1) ? S_COL : S_CMP;
                S_CMP:   r_state <= S_RD;
                S_RES: begin
                    if (!i_res_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tsdb_checker.sv
// Port-level checks for the triangle span depth buffer, bound to the top.
// Depends on tsdb_pkg.
`default_nettype none

module tsdb_port_checks
    import tsdb_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             push,
    input wire logic             full,
    input wire logic             pop,
    input wire logic             empty,
    input wire logic [DEP_W-1:0] o_read_depth,
    input wire logic [CNT_W-1:0] o_pixels_lowered,
    input wire logic             o_accepted
);

    // clearing pass holds off input and there is nothing to deliver
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> full && empty)
        else $error("not full and empty after reset");

    a_res_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty)
        else $error("result vanished without pop");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> $stable(o_read_depth) && $stable(o_pixels_lowered)
                           && $stable(o_accepted))
        else $error("result changed while stalled");

    // only an accepted triangle lowers cells, and it never reports a depth
    a_lowered_tri: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_pixels_lowered != '0 |-> o_accepted && o_read_depth == '0)
        else $error("lowered count on a non-triangle result");

    a_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_read_depth != '0 |-> o_accepted && o_pixels_lowered == '0)
        else $error("depth reported on a non-read result");

endmodule

bind triangle_span_depth_buffer tsdb_port_checks u_tsdb_port_checks (.*);

`default_nettype wire

FILE: verif/tsdb_checker.sv
// Checker for the triangle span depth buffer: watches both queue channels and
// the depth_limit write port, predicts each result word and compares it.
// Depends on tsdb_pkg.
`timescale 1ns / 1ps

module tsdb_checker
    import tsdb_pkg::*;
#(
    parameter int IMAGE_WIDTH  = 640,
    parameter int IMAGE_HEIGHT = 480
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic             i_full,
    input  wire logic [1:0]       i_action,
    input  wire logic [CX_W-1:0]  i_corner_a_x,
    input  wire logic [CY_W-1:0]  i_corner_a_y,
    input  wire logic [CX_W-1:0]  i_corner_b_x,
    input  wire logic [CY_W-1:0]  i_corner_b_y,
    input  wire logic [CX_W-1:0]  i_corner_c_x,
    input  wire logic [CY_W-1:0]  i_corner_c_y,
    input  wire logic [DEP_W-1:0] i_item_depth,
    input  wire logic             i_empty,
    input  wire logic             i_pop,
    input  wire logic [DEP_W-1:0] i_read_depth,
    input  wire logic [CNT_W-1:0] i_pixels_lowered,
    input  wire logic             i_accepted,
    input  wire logic             i_cfg_we,
    input  wire logic [DEP_W-1:0] i_cfg_wdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    logic [DEP_W-1:0] depth_cells [int];   // sparse copy, missing means empty
    logic [DEP_W-1:0] limit_q;
    t_res             result_q [$];
    int               lowered;

    initial o_fail_count = 0;
    assign o_pending = result_q.size();

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q--;
        return q;
    endfunction

    function automatic longint to_pixel(longint v);
        return (v + 32) >>> 6;
    endfunction

    function automatic bit on_screen(longint px, longint py);
        return px >= 1 && px <= IMAGE_WIDTH && py >= 1 && py <= IMAGE_HEIGHT;
    endfunction

    function automatic int cell_of(longint px, longint py);
        return int'((px - 1) * IMAGE_HEIGHT + (py - 1));
    endfunction

    // floor of the edge p-q in pixel rows at integer column k
    function automatic longint edge_row(longint px, longint py, longint qx, longint qy,
                                        longint k);
        longint den;
        den = qx - px;
        if (den <= 0)
            return floor_div(py, 64);
        return floor_div(py * den + (qy - py) * (k * 64 - px), 64 * den);
    endfunction

    task automatic lower_span(longint sx, longint ex, longint e[4], longint f[4],
                              logic [DEP_W-1:0] depth);
        longint k0, k1, r0, r1, f1, f2;
        int idx;
        k0 = floor_div(sx, 64) + 1;
        k1 = floor_div(ex, 64);
        if (k0 < 1) k0 = 1;
        if (k1 > IMAGE_WIDTH) k1 = IMAGE_WIDTH;
        for (longint k = k0; k <= k1; k++) begin
            f1 = edge_row(e[0], e[1], e[2], e[3], k);
            f2 = edge_row(f[0], f[1], f[2], f[3], k);
            r0 = (f1 < f2 ? f1 : f2) + 1;
            r1 = (f1 < f2 ? f2 : f1);
            if (r0 < 1) r0 = 1;
            if (r1 > IMAGE_HEIGHT) r1 = IMAGE_HEIGHT;
            for (longint r = r0; r <= r1; r++) begin
                idx = cell_of(k, r);
                if (depth_cells.exists(idx) && depth_cells[idx] != 0
                        && depth_cells[idx] > depth) begin
                    depth_cells[idx] = depth;
                    if (lowered < 65535)
                        lowered++;
                end
            end
        end
    endtask

    // returns 0 when a corner sits at the origin
    task automatic fill_triangle(output bit drawn);
        longint x[3], y[3], t;
        x[0] = i_corner_a_x; y[0] = i_corner_a_y;
        x[1] = i_corner_b_x; y[1] = i_corner_b_y;
        x[2] = i_corner_c_x; y[2] = i_corner_c_y;
        drawn = 1'b0;
        for (int i = 0; i < 3; i++)
            if (x[i] == 0 && y[i] == 0)
                return;
        drawn = 1'b1;
        // stable insertion sort on x
        for (int i = 1; i < 3; i++)
            for (int j = i; j > 0 && x[j-1] > x[j]; j--) begin
                t = x[j]; x[j] = x[j-1]; x[j-1] = t;
                t = y[j]; y[j] = y[j-1]; y[j-1] = t;
            end
        lower_span(x[0], x[1], '{x[0], y[0], x[1], y[1]}, '{x[0], y[0], x[2], y[2]},
                   i_item_depth);
        lower_span(x[1], x[2], '{x[1], y[1], x[2], y[2]}, '{x[0], y[0], x[2], y[2]},
                   i_item_depth);
    endtask

    task automatic predict_word();
        t_res   r;
        longint px, py;
        bit     drawn;
        int     idx;
        r  = '0;
        px = to_pixel(i_corner_a_x);
        py = to_pixel(i_corner_a_y);
        case (i_action)
            ACT_PLOT: begin
                if (on_screen(px, py)) begin
                    r.accepted = 1'b1;
                    if (i_item_depth < limit_q)
                        depth_cells[cell_of(px, py)] = i_item_depth;
                end
            end
            ACT_TRI: begin
                lowered = 0;
                fill_triangle(drawn);
                r.accepted       = drawn;
                r.pixels_lowered = CNT_W'(lowered);
            end
            ACT_READ: begin
                if (on_screen(px, py)) begin
                    r.accepted = 1'b1;
                    idx = cell_of(px, py);
                    r.read_depth = depth_cells.exists(idx) ? depth_cells[idx] : '0;
                end
            end
            default: begin
                depth_cells.delete();
                r.accepted = 1'b1;
            end
        endcase
        result_q = {result_q, r};
    endtask

    task automatic report(string what, int got, int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            limit_q = 16'd49152;
        end else begin
            // compare before predicting: a word pushed now cannot leave now
            if (i_pop && !i_empty) begin
                if (result_q.size() == 0) begin
                    $display("%0t: result word with nothing expected", $time);
                    o_fail_count++;
                end else begin
                    want = result_q.pop_front();
                    if (i_read_depth !== want.read_depth)
                        report("read_depth", i_read_depth, want.read_depth);
                    if (i_pixels_lowered !== want.pixels_lowered)
                        report("pixels_lowered", i_pixels_lowered, want.pixels_lowered);
                    if (i_accepted !== want.accepted)
                        report("accepted", i_accepted, want.accepted);
                end
            end
            if (i_push && !i_full)
                predict_word();
            if (i_cfg_we)
                limit_q = i_cfg_wdata;
        end
    end

endmodule

FILE: verif/tb.sv
// Top of the depth buffer testbench: clock, reset, stimulus, result-side
// stalls and verdict. Depends on tsdb_pkg, tsdb_checker and the block.
`timescale 1ns / 1ps

module tb;
    import tsdb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2_000_000;   // clears zero 307200 cells each
    localparam int PHASES         = 5;
    localparam int PHASE_WORDS    = 260;

    logic             i_clk;
    logic             i_rst_n = 1'b0;
    logic             push = 1'b0;
    logic             full;
    logic [1:0]       act = ACT_PLOT;
    logic [CX_W-1:0]  ax = '0, bx = '0, cx = '0;
    logic [CY_W-1:0]  ay = '0, by = '0, cy = '0;
    logic [DEP_W-1:0] dep = '0;
    logic             empty;
    logic             pop = 1'b0;
    logic [DEP_W-1:0] rd_depth;
    logic [CNT_W-1:0] lowered;
    logic             acc;
    logic             cfg_we = 1'b0;
    logic [DEP_W-1:0] cfg_wdata = '0;
    int               fail_count, pending;

    // idling is switched off for one whole phase to get back-to-back stretches
    bit               idle_on = 1'b1;
    int               words_sent = 0;
    int               clears = 0, triangles = 0;

    triangle_span_depth_buffer uut (
        .i_clk, .i_rst_n, .push, .full,
        .i_action(act), .i_corner_a_x(ax), .i_corner_a_y(ay),
        .i_corner_b_x(bx), .i_corner_b_y(by), .i_corner_c_x(cx), .i_corner_c_y(cy),
        .i_item_depth(dep), .empty, .pop,
        .o_read_depth(rd_depth), .o_pixels_lowered(lowered), .o_accepted(acc),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata)
    );

    tsdb_checker chk (
        .i_clk, .i_rst_n, .i_push(push), .i_full(full),
        .i_action(act), .i_corner_a_x(ax), .i_corner_a_y(ay),
        .i_corner_b_x(bx), .i_corner_b_y(by), .i_corner_c_x(cx), .i_corner_c_y(cy),
        .i_item_depth(dep), .i_empty(empty), .i_pop(pop),
        .i_read_depth(rd_depth), .i_pixels_lowered(lowered), .i_accepted(acc),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int p;
        if (!idle_on)
            return 0;
        p = $urandom_range(99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // offer one word and hold it until the queue takes it
    task automatic send(logic [1:0] a, int x0, int y0, int x1, int y1, int x2, int y2,
                        int d);
        int g;
        act <= a;
        ax  <= CX_W'(x0); ay <= CY_W'(y0);
        bx  <= CX_W'(x1); by <= CY_W'(y1);
        cx  <= CX_W'(x2); cy <= CY_W'(y2);
        dep <= DEP_W'(d);
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        words_sent++;
        if (a == ACT_CLEAR) clears++;
        if (a == ACT_TRI) triangles++;
        g = gap_len();
        if (g > 0) begin
            push <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // depth_limit is written only with nothing in flight
    task automatic set_limit(int v);
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= DEP_W'(v);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // small working window so plots and triangles overlap; 1/64 pixel units
    function automatic int win();
        return $urandom_range(0, 17 * 64);
    endfunction

    task automatic random_word();
        int p, bxx;
        p = $urandom_range(99);
        if (p < 38)
            send(ACT_PLOT, win(), win(), 0, 0, 0, 0, $urandom_range(1, 65535));
        else if (p < 42)
            send(ACT_PLOT, win(), win(), 0, 0, 0, 0, 0);
        else if (p < 64)
            send(ACT_TRI, win(), win(), win(), win(), win(), win(), $urandom_range(65535));
        else if (p < 88)
            send(ACT_READ, win(), win(), 0, 0, 0, 0, $urandom());
        else if (p < 95)
            // noise over the full field ranges
            send(($urandom_range(1) != 0) ? ACT_PLOT : ACT_READ,
                 $urandom_range(65535), $urandom_range(32767), $urandom(), $urandom(),
                 $urandom(), $urandom(), $urandom_range(65535));
        else begin
            // narrow but anywhere: every coordinate bit, bounded cost
            bxx = $urandom_range(65535);
            send(ACT_TRI, bxx, $urandom_range(32767),
                 (bxx + $urandom_range(512)) % 65536, $urandom_range(32767),
                 (bxx + $urandom_range(512)) % 65536, $urandom_range(32767),
                 $urandom_range(65535));
        end
    endtask

    // receiver: random pops, plus one long hold while the sender keeps going
    initial begin
        int g;
        bit held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && words_sent >= 150) begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (3000) @(posedge i_clk);
            end
            g = gap_len();
            if (g > 0) begin
                pop <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            pop <= 1'b1;
        end
    end

    // watchdog: cycles with no word accepted on either side
    initial begin
        int quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("timeout after %0d idle cycles", quiet);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        int limits [PHASES];
        limits = '{16'hFFFF, 16'h0000, 16'h0001, 16'd40000, 16'd49152};
        limits[2] = $urandom_range(1, 65534);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset limit first, 1.5 in Q1.15 must not store
        send(ACT_PLOT, 64, 64, 0, 0, 0, 0, 49152);
        send(ACT_READ, 64, 64, 0, 0, 0, 0, 0);
        send(ACT_PLOT, 64, 64, 0, 0, 0, 0, 49151);
        send(ACT_READ, 95, 95, 0, 0, 0, 0, 0);          // rounds down to 1,1
        send(ACT_PLOT, 96, 64, 0, 0, 0, 0, 1234);       // half rounds up to 2
        send(ACT_READ, 128, 64, 0, 0, 0, 0, 0);
        send(ACT_PLOT, 0, 64, 0, 0, 0, 0, 5);           // column 0, outside
        send(ACT_PLOT, 41087, 30783, 0, 0, 0, 0, 7);    // beyond both edges
        send(ACT_PLOT, 40960, 30720, 0, 0, 0, 0, 9);    // last pixel
        send(ACT_READ, 40960, 30720, 0, 0, 0, 0, 0);
        send(ACT_READ, 65535, 32767, 0, 0, 0, 0, 0);
        send(ACT_PLOT, 96, 64, 0, 0, 0, 0, 0);          // zero empties a cell
        for (int i = 1; i <= 6; i++)
            send(ACT_PLOT, i * 64, 128, 0, 0, 0, 0, 40000);
        send(ACT_TRI, 0, 0, 400, 400, 100, 300, 10);    // origin corner, skipped
        send(ACT_TRI, 64, 64, 64, 400, 448, 200, 100);  // vertical edge, ties
        send(ACT_TRI, 448, 64, 64, 300, 448, 300, 50);  // unsorted corners
        send(ACT_TRI, 64, 100, 41087, 200, 41087, 300, 20);   // full width, thin
        send(ACT_TRI, 100, 0, 130, 30783, 160, 100, 30);      // full height, narrow
        send(ACT_READ, 192, 128, 0, 0, 0, 0, 0);
        send(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        send(ACT_READ, 40960, 30720, 0, 0, 0, 0, 0);

        for (int ph = 0; ph < PHASES; ph++) begin
            set_limit(limits[ph]);
            idle_on = (ph != 3);
            if (ph == 2)
                send(ACT_CLEAR, $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom());
            for (int n = 0; n < PHASE_WORDS; n++)
                random_word();
        end

        push <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("covered %0d words: %0d triangles, %0d clears, %0d depth limits",
                 words_sent, triangles, clears, PHASES + 1);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/tsdb_pkg.sv
rtl/core/tsdb_fifo.sv
rtl/core/tsdb_front.sv
rtl/core/tsdb_div.sv
rtl/core/tsdb_back.sv
rtl/core/triangle_span_depth_buffer.sv
rtl/core/tsdb_checker.sv
verif/tsdb_checker.sv
verif/tb.sv
